// ===== sv/cnaw_pkg.sv =====
// Shared types, constants and helper functions of the cpio newc archive walker.
package cnaw_pkg;

  localparam int unsigned HDR_BYTES     = 110;
  localparam int unsigned FSIZE_FIRST   = 54;
  localparam int unsigned NSIZE_FIRST   = 94;
  localparam int unsigned HEX_CHARS     = 8;
  localparam int unsigned TRAILER_CHARS = 10;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_NAME    = 3'd1,
    PH_NAMEPAD = 3'd2,
    PH_DATA    = 3'd3,
    PH_DATAPAD = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_TRAILER = 2'd2
  } kind_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  name_char;
    logic [31:0] name_length;
    logic [31:0] data_length;
    logic [31:0] entry_offset;
  } result_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end
    return v;
  endfunction

  // Characters of the name that closes the archive.
  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = 8'h54;   // T
      4'd1: c = 8'h52;   // R
      4'd2: c = 8'h41;   // A
      4'd3: c = 8'h49;   // I
      4'd4: c = 8'h4C;   // L
      4'd5: c = 8'h45;   // E
      4'd6: c = 8'h52;   // R
      4'd7: c = 8'h21;   // !
      4'd8: c = 8'h21;   // !
      4'd9: c = 8'h21;   // !
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/cnaw_if.sv =====
// Valid/ready channel interfaces for archive bytes and walker results.
interface cnaw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] archive_byte;

  modport source (output valid, output archive_byte, input ready);
  modport sink (input valid, input archive_byte, output ready);
endinterface

interface cnaw_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  name_char;
  logic [31:0] name_length;
  logic [31:0] data_length;
  logic [31:0] entry_offset;

  modport source (output valid, output kind, output name_char, output name_length,
                  output data_length, output entry_offset, input ready);
  modport sink (input valid, input kind, input name_char, input name_length,
                input data_length, input entry_offset, output ready);
endinterface

// ===== sv/cnaw_parse.sv =====
// Walker state and per-byte parse logic; one byte is consumed per step.
module cnaw_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output cnaw_pkg::result_t   res_o
);

  cnaw_pkg::phase_e phase_q, phase_d;
  logic [31:0] count_q, count_d;
  logic [31:0] nsize_q, nsize_d;
  logic [31:0] fsize_q, fsize_d;
  logic [31:0] hdr_off_q, hdr_off_d;
  logic [31:0] byte_off_q, byte_off_d;
  logic        trl_match_q, trl_match_d;
  logic        name_ended_q, name_ended_d;

  logic [31:0]      count_inc;
  logic [1:0]       name_pad;
  logic [1:0]       data_pad;
  cnaw_pkg::phase_e data_entry;
  cnaw_pkg::phase_e name_exit;
  logic [3:0]       hex_val;
  logic             last_name;
  logic             fin;

  assign count_inc = count_q + 32'd1;
  assign hex_val   = cnaw_pkg::hex_digit(byte_i);

  always_comb begin
    phase_d      = phase_q;
    count_d      = count_q;
    nsize_d      = nsize_q;
    fsize_d      = fsize_q;
    hdr_off_d    = hdr_off_q;
    byte_off_d   = byte_off_q;
    trl_match_d  = trl_match_q;
    name_ended_d = name_ended_q;
    res_o        = '0;
    last_name    = 1'b0;
    fin          = 1'b0;

    if (step_i && phase_q == cnaw_pkg::PH_HEADER) begin
      if (count_q == 32'd0) begin
        nsize_d      = 32'd0;
        fsize_d      = 32'd0;
        hdr_off_d    = byte_off_q;
        trl_match_d  = 1'b1;
        name_ended_d = 1'b0;
      end
      if (count_q >= 32'(cnaw_pkg::FSIZE_FIRST) &&
          count_q < 32'(cnaw_pkg::FSIZE_FIRST + cnaw_pkg::HEX_CHARS)) begin
        fsize_d = {fsize_q[27:0], hex_val};
      end
      if (count_q >= 32'(cnaw_pkg::NSIZE_FIRST) &&
          count_q < 32'(cnaw_pkg::NSIZE_FIRST + cnaw_pkg::HEX_CHARS)) begin
        nsize_d = {nsize_q[27:0], hex_val};
      end
    end

    // Padding after header plus name, and after the data, both to four bytes.
    name_pad = 2'(2'd2 - nsize_d[1:0]);
    data_pad = 2'(2'd0 - fsize_d[1:0]);
    if (fsize_d != 32'd0) begin
      data_entry = cnaw_pkg::PH_DATA;
    end else if (data_pad != 2'd0) begin
      data_entry = cnaw_pkg::PH_DATAPAD;
    end else begin
      data_entry = cnaw_pkg::PH_HEADER;
    end
    name_exit = (name_pad != 2'd0) ? cnaw_pkg::PH_NAMEPAD : data_entry;

    if (step_i) begin
      case (phase_q)
        cnaw_pkg::PH_HEADER: begin
          byte_off_d = byte_off_q + 32'd1;
          count_d    = count_inc;
          if (count_inc == 32'(cnaw_pkg::HDR_BYTES)) begin
            count_d = 32'd0;
            if (nsize_d == 32'd0) begin
              // An empty name closes the entry on the last header byte.
              res_o.valid = 1'b1;
              res_o.kind  = cnaw_pkg::KIND_ENTRY;
              phase_d     = name_exit;
            end else begin
              phase_d = cnaw_pkg::PH_NAME;
            end
          end
        end
        cnaw_pkg::PH_NAME: begin
          byte_off_d = byte_off_q + 32'd1;
          count_d    = count_inc;
          last_name  = (count_q == nsize_q - 32'd1);
          if (!name_ended_q) begin
            if (byte_i == 8'd0) begin
              name_ended_d = 1'b1;
              if (count_q != 32'(cnaw_pkg::TRAILER_CHARS)) begin
                trl_match_d = 1'b0;
              end
            end else if (count_q >= 32'(cnaw_pkg::TRAILER_CHARS) ||
                         byte_i != cnaw_pkg::trailer_char(count_q[3:0])) begin
              trl_match_d = 1'b0;
            end
          end
          fin = trl_match_d &&
                (name_ended_d || nsize_q == 32'(cnaw_pkg::TRAILER_CHARS));
          if (last_name) begin
            res_o.valid = 1'b1;
            res_o.kind  = fin ? cnaw_pkg::KIND_TRAILER : cnaw_pkg::KIND_ENTRY;
            count_d     = 32'd0;
            phase_d     = fin ? cnaw_pkg::PH_DONE : name_exit;
          end else if (!name_ended_q && byte_i != 8'd0) begin
            res_o.valid     = 1'b1;
            res_o.kind      = cnaw_pkg::KIND_CHAR;
            res_o.name_char = byte_i;
          end
        end
        cnaw_pkg::PH_NAMEPAD: begin
          byte_off_d = byte_off_q + 32'd1;
          count_d    = count_inc;
          if (count_inc >= 32'(name_pad)) begin
            count_d = 32'd0;
            phase_d = data_entry;
          end
        end
        cnaw_pkg::PH_DATA: begin
          byte_off_d = byte_off_q + 32'd1;
          count_d    = count_inc;
          if (count_inc == fsize_q) begin
            count_d = 32'd0;
            phase_d = (data_pad != 2'd0) ? cnaw_pkg::PH_DATAPAD : cnaw_pkg::PH_HEADER;
          end
        end
        cnaw_pkg::PH_DATAPAD: begin
          byte_off_d = byte_off_q + 32'd1;
          count_d    = count_inc;
          if (count_inc >= 32'(data_pad)) begin
            count_d = 32'd0;
            phase_d = cnaw_pkg::PH_HEADER;
          end
        end
        default: begin
          // Trailer seen: every later byte is dropped until reset.
        end
      endcase
    end

    res_o.name_length  = nsize_d;
    res_o.data_length  = fsize_d;
    res_o.entry_offset = hdr_off_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= cnaw_pkg::PH_HEADER;
      count_q      <= 32'd0;
      nsize_q      <= 32'd0;
      fsize_q      <= 32'd0;
      hdr_off_q    <= 32'd0;
      byte_off_q   <= 32'd0;
      trl_match_q  <= 1'b1;
      name_ended_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      count_q      <= count_d;
      nsize_q      <= nsize_d;
      fsize_q      <= fsize_d;
      hdr_off_q    <= hdr_off_d;
      byte_off_q   <= byte_off_d;
      trl_match_q  <= trl_match_d;
      name_ended_q <= name_ended_d;
    end
  end

endmodule

// ===== sv/cpio_newc_archive_walker.sv =====
// Walks a cpio newc archive fed one byte per beat and reports names and entries.
//
// Channels: byte_i carries the archive one byte per beat, in order.
// result_o carries at most one result per byte: a name character (kind 0),
// an entry closed (kind 1, with name size, file size and header offset) or
// the trailer entry (kind 2). Padding and data bytes give no result; header
// bytes give none either, but for the last one of an entry with an empty name.
// Path: an accepted byte is held in the input byte register, and its result,
// if any, is registered in the result register and offered on result_o.
// Throughput: one byte per cycle unless result_o stalls; the parse state update
// for a byte is a single pass of logic between these two registers.
// Reset: the walker expects a new header at archive offset zero and both
// channels come up empty.
// Stall: while a result waits on result_o, the input register still holds
// one more byte; further bytes are refused until the result is taken.
// After the trailer entry, bytes are accepted and dropped until reset.
module cpio_newc_archive_walker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cnaw_byte_if.sink             byte_i,
  cnaw_result_if.source         result_o
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              step;
  cnaw_pkg::result_t res;

  logic              out_valid_q, out_valid_d;
  cnaw_pkg::kind_e   kind_q;
  logic [7:0]        name_char_q;
  logic [31:0]       name_length_q;
  logic [31:0]       data_length_q;
  logic [31:0]       entry_offset_q;

  // The held byte moves on once the result register can take its result.
  assign step         = in_valid_q && (!out_valid_q || result_o.ready);
  assign byte_i.ready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (byte_i.valid && byte_i.ready) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step && res.valid) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.archive_byte;
    end
    if (step && res.valid) begin
      kind_q         <= res.kind;
      name_char_q    <= res.name_char;
      name_length_q  <= res.name_length;
      data_length_q  <= res.data_length;
      entry_offset_q <= res.entry_offset;
    end
  end

  cnaw_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  assign result_o.valid        = out_valid_q;
  assign result_o.kind         = kind_q;
  assign result_o.name_char    = name_char_q;
  assign result_o.name_length  = name_length_q;
  assign result_o.data_length  = data_length_q;
  assign result_o.entry_offset = entry_offset_q;

  // Nothing follows the trailer entry.
  a_done_after_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_o.ready && kind_q == cnaw_pkg::KIND_TRAILER) |=> !out_valid_q)
    else $error("result produced after trailer entry");

  // Name characters are never NUL, and other kinds carry a zero character.
  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((kind_q == cnaw_pkg::KIND_CHAR) == (name_char_q != 8'd0)))
    else $error("name character field inconsistent with kind");

  // A held byte is not dropped while the result side is stalled.
  a_hold_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("input byte lost during stall");

endmodule
